FILE: rtl/door_mode_controller_defines.svh
// Assertion macros shared by the door controller RTL.
// Each macro takes a label, a property expression and a message string.
`ifndef DOOR_MODE_CONTROLLER_DEFINES_SVH
`define DOOR_MODE_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of aclk while the block is out of reset.
`define DMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define DMC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`else

`define DMC_ASSERT(label, prop, msg)
`define DMC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: rtl/dmc_pkg.sv
package dmc_pkg;

    // Widths of the sample word, the result fields and the registers.
    localparam int SAMPLE_W = 11;
    localparam int DRIVE_W  = 3;
    localparam int PHASE_W  = 3;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // Default width of the hold counter.
    localparam int HOLD_WIDTH_DEF = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIM_MODE     = 1'd1;

    // Register reset values.
    localparam logic [CFG_W-1:0] HOLD_SAMPLES_RST = 8'd67;

    // Phase codes.
    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_OPEN  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_EXTRA = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CLOSE = 3'd4;

    // Motor drive codes.
    localparam logic [DRIVE_W-1:0] DRV_REST  = 3'd0;
    localparam logic [DRIVE_W-1:0] DRV_OPEN  = 3'd1;
    localparam logic [DRIVE_W-1:0] DRV_CLOSE = 3'd6;

    // Bit positions in the sample word.
    localparam int B_S1 = 0;
    localparam int B_S2 = 1;
    localparam int B_E1 = 2;
    localparam int B_E2 = 3;
    localparam int B_X1 = 4;
    localparam int B_X2 = 5;
    localparam int B_X3 = 6;
    localparam int B_SENSOR_LO = 7;
    localparam int B_SENSOR_HI = 10;

    // Any of the four active-low sensors asserted.
    function automatic logic any_sensor_low(input logic [SAMPLE_W-1:0] s);
        return ~&s[B_SENSOR_HI:B_SENSOR_LO];
    endfunction

    // Both closed-limit inputs high means the door is not closed.
    function automatic logic door_not_closed(input logic [SAMPLE_W-1:0] s);
        return s[B_X2] & s[B_X3];
    endfunction

endpackage

FILE: rtl/door_mode_controller.sv
// Channel   Dir  Payload (tdata, lowest bit first)
// s_axis    in   sample_word[10:0], zero fill to 16 bits
// m_axis    out  drive_code[2:0], halted[0], phase[2:0], zero fill to 8 bits
// cfg       in   cfg_we, cfg_addr (0 hold_samples, 1 sim_mode), cfg_wdata[7:0]
//
// One sample beat is taken per cycle unless the output side stalls; its result appears
// in the output register on the next cycle.
// The next-state logic and the output register set the rate of one beat a cycle.
// A new beat is taken while the output register is empty or being drained.
// aresetn is synchronous and active low; it resets the state, the configuration registers and the output valid flag.
`include "door_mode_controller_defines.svh"

module door_mode_controller
    import dmc_pkg::*;
#(
    parameter int HOLD_WIDTH = HOLD_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Sample input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sample_word[10:0]
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // drive_code[2:0], halted, phase[2:0]
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    // Width that holds both the register value and the counter maximum.
    localparam int CMP_W = (HOLD_WIDTH > CFG_W) ? HOLD_WIDTH : CFG_W;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((64'd1 << HOLD_WIDTH) - 64'd1);

    // Configuration registers.
    logic [CFG_W-1:0] hold_samples_reg;
    logic             sim_mode_reg;

    // Controller state.
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic                  mode_auto_reg, mode_auto_next;
    logic [HOLD_WIDTH-1:0] hold_count_reg, hold_count_next;
    logic                  stopped_reg, stopped_next;
    logic [DRIVE_W-1:0]    drive_reg, drive_next;

    // Output register.
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic                  accept;
    logic [SAMPLE_W-1:0]   s;
    logic [CMP_W-1:0]      lim_wide;
    logic [HOLD_WIDTH-1:0] limit;
    logic [HOLD_WIDTH-1:0] cnt_inc;
    logic                  cnt_done;
    logic [PHASE_W-1:0]    open_phase, close_phase;
    logic [DRIVE_W-1:0]    open_drive, close_drive;
    logic                  close_to_open;
    logic                  reopen_req;
    logic                  hold_req;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign s        = s_tdata[SAMPLE_W-1:0];

    // Interval limit: a zero register counts as one, and it saturates at the counter maximum.
    always_comb begin
        lim_wide = (hold_samples_reg == '0) ? CMP_W'(1) : CMP_W'(hold_samples_reg);
        if (lim_wide > CNT_MAX) begin
            lim_wide = CNT_MAX;
        end
        limit = lim_wide[HOLD_WIDTH-1:0];
    end

    assign cnt_inc  = hold_count_reg + HOLD_WIDTH'(1);
    assign cnt_done = cnt_inc >= limit;

    // Opening goes straight to holding when the door is already fully open.
    assign open_phase = s[B_X1] ? PH_OPEN : PH_HOLD;
    assign open_drive = s[B_X1] ? DRV_OPEN : DRV_REST;

    // Requests that depend on the mode.
    assign reopen_req = mode_auto_reg ? any_sensor_low(s) : !s[B_E1];
    assign hold_req   = mode_auto_reg ? any_sensor_low(s) : s[B_E2];

    // Close step: keep closing, reopen on a request, or rest once closed.
    always_comb begin
        close_to_open = 1'b0;
        close_phase   = PH_IDLE;
        close_drive   = DRV_REST;
        if (door_not_closed(s)) begin
            if (reopen_req) begin
                close_to_open = 1'b1;
                close_phase   = open_phase;
                close_drive   = open_drive;
            end else begin
                close_phase = PH_CLOSE;
                close_drive = DRV_CLOSE;
            end
        end
    end

    // Next-state logic for one sample.
    always_comb begin
        phase_next      = phase_reg;
        mode_auto_next  = mode_auto_reg;
        hold_count_next = hold_count_reg;
        stopped_next    = stopped_reg;
        drive_next      = drive_reg;
        if (!stopped_reg) begin
            case (phase_reg)
                PH_OPEN: begin
                    if (s[B_X1]) begin
                        drive_next = DRV_OPEN;
                    end else begin
                        drive_next      = DRV_REST;
                        phase_next      = PH_HOLD;
                        hold_count_next = '0;
                    end
                end
                PH_HOLD: begin
                    hold_count_next = cnt_inc;
                    if (cnt_done) begin
                        if (hold_req) begin
                            drive_next      = DRV_REST;
                            phase_next      = PH_HOLD;
                            hold_count_next = '0;
                        end else if (mode_auto_reg) begin
                            phase_next      = PH_EXTRA;
                            hold_count_next = '0;
                        end else begin
                            phase_next = close_phase;
                            drive_next = close_drive;
                            if (close_to_open && !s[B_X1]) begin
                                hold_count_next = '0;
                            end
                        end
                    end
                end
                PH_EXTRA: begin
                    hold_count_next = cnt_inc;
                    if (cnt_done) begin
                        phase_next = close_phase;
                        drive_next = close_drive;
                        if (close_to_open && !s[B_X1]) begin
                            hold_count_next = '0;
                        end
                    end
                end
                PH_CLOSE: begin
                    phase_next = close_phase;
                    drive_next = close_drive;
                    if (close_to_open && !s[B_X1]) begin
                        hold_count_next = '0;
                    end
                end
                default: begin
                    // Idle: decode the mode switches.
                    phase_next = PH_IDLE;
                    if (s[B_S1] && s[B_S2]) begin
                        drive_next = DRV_REST;
                    end else if (s[B_S1]) begin
                        // Repair mode leaves everything as it is.
                    end else if (door_not_closed(s) && !sim_mode_reg) begin
                        stopped_next = 1'b1;
                    end else if (s[B_S2]) begin
                        mode_auto_next = 1'b0;
                        if (!s[B_E1]) begin
                            phase_next = open_phase;
                            drive_next = open_drive;
                            if (!s[B_X1]) begin
                                hold_count_next = '0;
                            end
                        end
                    end else begin
                        mode_auto_next = 1'b1;
                        if (any_sensor_low(s)) begin
                            phase_next = open_phase;
                            drive_next = open_drive;
                            if (!s[B_X1]) begin
                                hold_count_next = '0;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_samples_reg <= HOLD_SAMPLES_RST;
            sim_mode_reg     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_HOLD_SAMPLES: hold_samples_reg <= cfg_wdata;
                REG_SIM_MODE:     sim_mode_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // State update on each accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            mode_auto_reg  <= 1'b0;
            hold_count_reg <= '0;
            stopped_reg    <= 1'b0;
            drive_reg      <= DRV_REST;
        end else if (accept) begin
            phase_reg      <= phase_next;
            mode_auto_reg  <= mode_auto_next;
            hold_count_reg <= hold_count_next;
            stopped_reg    <= stopped_next;
            drive_reg      <= drive_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload: a halted controller reports the idle phase.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {1'b0,
                           stopped_next ? PH_IDLE : phase_next,
                           stopped_next,
                           drive_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Once halted, the controller never resumes.
    `DMC_ASSERT(a_halt_sticky, stopped_reg |=> stopped_reg, "halted state was left")

    // A halted result always reports the idle phase.
    `DMC_ASSERT(a_halt_phase, (m_tvalid && m_tdata[3]) |-> (m_tdata[6:4] == PH_IDLE),
        "halted result with a non-idle phase")

    // The close drive is only shown while closing.
    `DMC_ASSERT(a_close_drive, (m_tvalid && !m_tdata[3] && m_tdata[2:0] == DRV_CLOSE)
        |-> (m_tdata[6:4] == PH_CLOSE), "close drive outside the closing phase")

    // Every accepted sample produces a result on the next cycle.
    `DMC_ASSERT(a_result_follows, accept |=> m_tvalid, "accepted beat gave no result")

endmodule

FILE: bench/door_mode_controller_test.sv
`timescale 1ns / 100ps

module door_mode_controller_test
    import dmc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam logic [3:0] SENS_QUIET = 4'hF;   // no sensor asks
    localparam logic [3:0] SENS_LS1   = 4'hE;   // first sensor low only

    // One beat on the result stream, split into its fields.
    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               halted;
        logic [PHASE_W-1:0] phase;
    } door_result_t;

    // Rows of the directed plan: a sample beat or a register write.
    typedef enum bit {ROW_BEAT, ROW_REG} row_kind_t;
    typedef struct {
        row_kind_t            kind;
        logic [SAMPLE_W-1:0]  smp;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        bit                   typed;
        door_result_t         res;
    } plan_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // sample_word[10:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;          // drive_code[2:0], halted, phase[2:0]
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Predicted controller state and register copies.
    logic [PHASE_W-1:0] door_ph   = PH_IDLE;
    logic               door_auto = 1'b0;
    logic [7:0]         door_cnt  = '0;
    logic               door_halt = 1'b0;
    logic [DRIVE_W-1:0] door_drv  = DRV_REST;
    logic [CFG_W-1:0]   cfg_hold  = HOLD_SAMPLES_RST;
    logic               cfg_sim   = 1'b0;

    door_result_t outputs_due[$];
    plan_row_t    plan[$];
    door_result_t want_res;
    bit           idling_on = 1'b1;
    int           mismatches = 0;
    int           stall_left = 0;
    int           stuck_cycles = 0;

    door_mode_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Builds a sample word from its switch, button, limit and sensor bits.
    function automatic logic [SAMPLE_W-1:0] word(input bit s1, s2, e1, e2, x1, x2, x3,
                                                 input logic [3:0] sens);
        logic [SAMPLE_W-1:0] w;
        w = '0;
        w[B_S1] = s1;
        w[B_S2] = s2;
        w[B_E1] = e1;
        w[B_E2] = e2;
        w[B_X1] = x1;
        w[B_X2] = x2;
        w[B_X3] = x3;
        w[B_SENSOR_HI:B_SENSOR_LO] = sens;
        return w;
    endfunction

    function automatic bit sensors_request(input logic [SAMPLE_W-1:0] s);
        return s[B_SENSOR_HI:B_SENSOR_LO] != 4'hF;
    endfunction

    function automatic bit door_ajar(input logic [SAMPLE_W-1:0] s);
        return s[B_X2] && s[B_X3];
    endfunction

    function automatic void begin_hold();
        door_drv = DRV_REST;
        door_ph  = PH_HOLD;
        door_cnt = '0;
    endfunction

    // Drives open unless the open limit is already reached.
    function automatic void begin_open(input logic [SAMPLE_W-1:0] s);
        if (s[B_X1]) begin
            door_drv = DRV_OPEN;
            door_ph  = PH_OPEN;
        end else begin
            begin_hold();
        end
    endfunction

    // Closes, reopens on a request, or comes to rest once the door is shut.
    function automatic void close_or_reopen(input logic [SAMPLE_W-1:0] s);
        bit req;
        req = door_auto ? sensors_request(s) : !s[B_E1];
        if (!door_ajar(s)) begin
            door_drv = DRV_REST;
            door_ph  = PH_IDLE;
        end else if (req) begin
            begin_open(s);
        end else begin
            door_drv = DRV_CLOSE;
            door_ph  = PH_CLOSE;
        end
    endfunction

    // A hold interval of zero samples counts as one.
    function automatic bit interval_elapsed();
        door_cnt = door_cnt + 8'd1;
        return door_cnt >= ((cfg_hold == '0) ? 8'd1 : cfg_hold);
    endfunction

    // Advances the predicted controller by one sample and returns its outputs.
    function automatic door_result_t predict_outputs(input logic [SAMPLE_W-1:0] s);
        door_result_t r;
        bit req;
        if (!door_halt) begin
            case (door_ph)
                PH_OPEN: begin
                    if (s[B_X1]) door_drv = DRV_OPEN;
                    else begin_hold();
                end
                PH_HOLD: begin
                    if (interval_elapsed()) begin
                        req = door_auto ? sensors_request(s) : s[B_E2];
                        if (req) begin
                            begin_hold();
                        end else if (door_auto) begin
                            door_ph  = PH_EXTRA;
                            door_cnt = '0;
                        end else begin
                            close_or_reopen(s);
                        end
                    end
                end
                PH_EXTRA: begin
                    if (interval_elapsed()) close_or_reopen(s);
                end
                PH_CLOSE: begin
                    close_or_reopen(s);
                end
                default: begin
                    door_ph = PH_IDLE;
                    // Off rests the motor, repair leaves everything as it is.
                    if (s[B_S1] && s[B_S2]) begin
                        door_drv = DRV_REST;
                    end else if (!s[B_S1]) begin
                        if (door_ajar(s) && !cfg_sim) begin
                            door_halt = 1'b1;
                        end else if (s[B_S2]) begin
                            door_auto = 1'b0;
                            if (!s[B_E1]) begin_open(s);
                        end else begin
                            door_auto = 1'b1;
                            if (sensors_request(s)) begin_open(s);
                        end
                    end
                end
            endcase
        end
        r.drive  = door_drv;
        r.halted = door_halt;
        r.phase  = door_halt ? PH_IDLE : door_ph;
        return r;
    endfunction

    // Random sample, mostly shaped to move the controller on from its phase.
    function automatic logic [SAMPLE_W-1:0] gen_sample(input bit allow_halt);
        logic [SAMPLE_W-1:0] s;
        bit req;
        bit ajar;
        s = SAMPLE_W'($urandom);
        req = ($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 99) >= 15) begin
            case (door_ph)
                PH_IDLE: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: begin
                            s[B_S1] = 1'b0;
                            s[B_S2] = 1'b0;
                            s[B_SENSOR_HI:B_SENSOR_LO] = SENS_QUIET;
                            if ($urandom_range(0, 3) != 0)
                                s[B_SENSOR_LO + $urandom_range(0, 3)] = 1'b0;
                        end
                        5, 6, 7: begin
                            s[B_S1] = 1'b0;
                            s[B_S2] = 1'b1;
                            s[B_E1] = ($urandom_range(0, 3) == 0);
                        end
                        default: s[B_S1] = 1'b1;
                    endcase
                    s[B_X1] = ($urandom_range(0, 3) != 0);
                end
                PH_OPEN: s[B_X1] = ($urandom_range(0, 3) != 0);
                PH_HOLD, PH_EXTRA: begin
                    if (door_auto) begin
                        s[B_SENSOR_HI:B_SENSOR_LO] = SENS_QUIET;
                        if (req) s[B_SENSOR_LO + $urandom_range(0, 3)] = 1'b0;
                    end else begin
                        s[B_E2] = req;
                    end
                end
                default: begin
                    ajar = ($urandom_range(0, 9) < 7);
                    s[B_X2] = ajar | s[B_X2];
                    s[B_X3] = ajar;
                    req = ($urandom_range(0, 3) == 0);
                    if (door_auto) begin
                        s[B_SENSOR_HI:B_SENSOR_LO] = SENS_QUIET;
                        if (req) s[B_SENSOR_LO + $urandom_range(0, 3)] = 1'b0;
                    end else begin
                        s[B_E1] = !req;
                    end
                end
            endcase
        end
        // Keep the door shut at idle unless halting is wanted in this part.
        if (!allow_halt && !cfg_sim && !door_halt && door_ph == PH_IDLE)
            s[B_X3] = 1'b0;
        return s;
    endfunction

    function automatic void add_beat(input logic [SAMPLE_W-1:0] smp, input bit typed = 1'b0,
                                     input door_result_t res = '0);
        plan_row_t row;
        row.kind  = ROW_BEAT;
        row.smp   = smp;
        row.idx   = '0;
        row.val   = '0;
        row.typed = typed;
        row.res   = res;
        plan.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        plan_row_t row;
        row.kind  = ROW_REG;
        row.smp   = '0;
        row.idx   = idx;
        row.val   = val;
        row.typed = 1'b0;
        row.res   = '0;
        plan.push_back(row);
    endfunction

    // Offers one sample beat, sometimes after a random gap, and books its outputs.
    task automatic send_beat(input logic [SAMPLE_W-1:0] smp, input bit typed,
                             input door_result_t res);
        door_result_t pred;
        if (idling_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tdata  <= S_TDATA_W'(smp);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pred = predict_outputs(smp);
        outputs_due.push_back(typed ? res : pred);
    endtask

    // Stops offering beats and waits for every booked result.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == REG_HOLD_SAMPLES) cfg_hold = val;
        else cfg_sim = val[0];
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_random(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] sim,
                              input int beats, input bit allow_halt);
        drain();
        write_reg(REG_HOLD_SAMPLES, hold);
        write_reg(REG_SIM_MODE, sim);
        repeat (beats) send_beat(gen_sample(allow_halt), 1'b0, '0);
    endtask

    // Result side: check each beat against the oldest booking, stall in bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (outputs_due.size() == 0) begin
                $display("%0t: result beat %h arrived with nothing expected", $time, m_tdata);
                mismatches++;
            end else begin
                want_res = outputs_due.pop_front();
                if (m_tdata[2:0] !== want_res.drive) begin
                    $display("%0t: drive_code expected %0d, got %0d",
                             $time, want_res.drive, m_tdata[2:0]);
                    mismatches++;
                end
                if (m_tdata[3] !== want_res.halted) begin
                    $display("%0t: halted expected %0d, got %0d",
                             $time, want_res.halted, m_tdata[3]);
                    mismatches++;
                end
                if (m_tdata[6:4] !== want_res.phase) begin
                    $display("%0t: phase expected %0d, got %0d",
                             $time, want_res.phase, m_tdata[6:4]);
                    mismatches++;
                end
            end
        end
        if (stall_left != 0) stall_left--;
        else if (idling_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 15);
        m_tready <= (stall_left == 0);
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        // Reset defaults first: off, repair with the door open, hand and
        // automatic with nothing asking.
        add_beat(11'h7FF, 1'b1, '{DRV_REST, 1'b0, PH_IDLE});
        add_beat(word(1, 0, 1, 0, 1, 1, 1, SENS_QUIET), 1'b1, '{DRV_REST, 1'b0, PH_IDLE});
        add_beat(word(0, 1, 1, 0, 1, 0, 0, SENS_QUIET), 1'b1, '{DRV_REST, 1'b0, PH_IDLE});
        add_beat(word(0, 0, 1, 0, 1, 0, 0, SENS_QUIET), 1'b1, '{DRV_REST, 1'b0, PH_IDLE});
        add_reg(REG_HOLD_SAMPLES, 8'd1);
        // Automatic cycle: already at the open limit, extra wait, reopen on a
        // request as it ends, re-hold on a request, close and come to rest.
        add_beat(11'h000, 1'b1, '{DRV_REST, 1'b0, PH_HOLD});
        add_beat(word(0, 0, 1, 0, 0, 0, 0, SENS_QUIET));
        add_beat(word(0, 0, 1, 0, 1, 1, 1, SENS_LS1));
        add_beat(word(0, 0, 1, 0, 1, 1, 1, SENS_QUIET));
        add_beat(word(0, 0, 1, 0, 0, 1, 1, SENS_QUIET));
        add_beat(word(0, 0, 1, 0, 0, 1, 1, 4'h7));
        add_beat(word(0, 0, 1, 0, 0, 1, 1, SENS_QUIET));
        add_beat(word(0, 0, 1, 0, 0, 1, 1, SENS_QUIET));
        add_beat(word(0, 0, 1, 0, 0, 0, 0, SENS_QUIET));
        // Hand cycle: open button, hold request, close, reopen on the button.
        add_beat(word(0, 1, 0, 0, 1, 0, 0, SENS_QUIET));
        add_beat(word(0, 1, 1, 0, 0, 1, 1, SENS_QUIET));
        add_beat(word(0, 1, 1, 1, 0, 1, 1, SENS_QUIET));
        add_beat(word(0, 1, 1, 0, 0, 1, 1, SENS_QUIET));
        add_beat(word(0, 1, 0, 0, 1, 1, 1, SENS_QUIET));
        add_beat(word(0, 1, 1, 0, 0, 1, 1, SENS_QUIET));
        add_beat(word(0, 1, 1, 0, 0, 0, 0, SENS_QUIET));
        // Zero hold interval, and simulation mode letting an open door start.
        add_reg(REG_HOLD_SAMPLES, 8'd0);
        add_reg(REG_SIM_MODE, 8'hFF);
        add_beat(word(0, 1, 0, 0, 0, 1, 1, SENS_QUIET));
        add_beat(word(0, 1, 1, 0, 0, 1, 1, SENS_QUIET), 1'b1, '{DRV_CLOSE, 1'b0, PH_CLOSE});
        add_beat(word(0, 1, 1, 0, 0, 1, 1, SENS_QUIET));
        add_beat(word(0, 1, 1, 0, 0, 0, 1, SENS_QUIET));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                drain();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_beat(plan[i].smp, plan[i].typed, plan[i].res);
            end
        end

        // Random phases over several settings; the last lets the block halt.
        run_random(8'd2, 8'h01, 120, 1'b0);
        run_random(8'd255, 8'hFE, 270, 1'b0);
        run_random(8'd1, 8'h03, 80, 1'b0);
        drain();
        idling_on = 1'b0;
        run_random(8'd5, 8'h00, 60, 1'b1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outputs_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
